FILE: rtl/core/npf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder package
// Shared widths, constants and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package npf_pkg;

	localparam int IN_W   = 32;
	localparam int CAND_W = 31;
	localparam int DIV_W  = 17;
	localparam int DSQ_W  = 34;
	localparam int REM_STEPS = 16;
	localparam int CNT_W  = 4;

	localparam logic [CAND_W-1:0] CAND_TWO   = CAND_W'(2);
	localparam logic [CAND_W-1:0] CAND_THREE = CAND_W'(3);
	localparam logic [DIV_W-1:0]  DIV_FIRST  = DIV_W'(3);
	localparam logic [DSQ_W-1:0]  DSQ_FIRST  = DSQ_W'(9);

	typedef struct packed {
		logic load;
		logic next_cand;
		logic init_div;
		logic next_div;
		logic start_rem;
		logic load_out;
	} npf_cmd_t;

	typedef struct packed {
		logic cand_le3;
		logic cand_even;
		logic dsq_gt;
		logic rem_done;
		logic rem_zero;
	} npf_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/next_prime_finder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder unit
// Returns the smallest prime not less than a signed 32-bit start value.
// ----------------------------------------------------------------------------
// Each input word yields one output word: the smallest prime at or above the
// start value, or 2 for start values below 2. Candidates are tested in
// increasing order; even candidates above 2 are skipped without a division,
// and odd ones are divided by 3, 5, 7 and so on up to the square root in a
// shared remainder unit. The time per word is therefore data dependent and
// grows with the number of trial divisors that a candidate needs. One word
// is processed at a time; a finished result sits in an output register, and
// the next start value is taken as soon as that result has been moved into
// it.
// ----------------------------------------------------------------------------
module next_prime_finder_unit
	import npf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [IN_W-1:0]   start_value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [CAND_W-1:0]      prime
);

	npf_cmd_t cmd;
	npf_sts_t sts;

	npf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	npf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.start_value (start_value),
		.sts         (sts),
		.prime       (prime)
	);

endmodule
`default_nettype wire

FILE: rtl/core/npf_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder remainder unit
// Restoring remainder of a 31-bit dividend by a 17-bit divisor, two
// quotient bits per cycle, with a one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
module npf_rem
	import npf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [CAND_W-1:0] dividend,
	input  wire logic [DIV_W-1:0]  divisor,
	output logic                   done,
	output logic                   zero
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IN_W-1:0]  sh_q;
	logic [DIV_W-1:0] r_q;
	logic [DIV_W:0]   t1;
	logic [DIV_W:0]   t2;
	logic [DIV_W-1:0] r1;
	logic [DIV_W-1:0] r2;

	always_comb begin
		t1 = {r_q, sh_q[IN_W-1]};
		if (t1 >= {1'b0, divisor}) begin
			t1 = t1 - {1'b0, divisor};
		end
		r1 = t1[DIV_W-1:0];
		t2 = {r1, sh_q[IN_W-2]};
		if (t2 >= {1'b0, divisor}) begin
			t2 = t2 - {1'b0, divisor};
		end
		r2 = t2[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= {1'b0, dividend};
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[IN_W-3:0], 2'b00};
			r_q  <= r2;
		end
	end

	assign done = done_q;
	assign zero = (r_q == '0);

endmodule
`default_nettype wire

FILE: rtl/core/npf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder datapath
// Holds the candidate, the trial divisor and its square, the remainder unit
// and the output word register.
// ----------------------------------------------------------------------------
module npf_dp
	import npf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire npf_cmd_t          cmd,
	input  wire logic [IN_W-1:0]   start_value,
	output npf_sts_t               sts,
	output logic [CAND_W-1:0]      prime
);

	logic [CAND_W-1:0] cand_q;
	logic [DIV_W-1:0]  d_q;
	logic [DSQ_W-1:0]  dsq_q;
	logic [CAND_W-1:0] prime_q;
	logic              small_in;
	logic              rem_done;
	logic              rem_zero;

	assign small_in = start_value[IN_W-1] || (start_value < IN_W'(2));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q <= small_in ? CAND_TWO : start_value[CAND_W-1:0];
		end else if (cmd.next_cand) begin
			cand_q <= cand_q + CAND_W'(1);
		end
		if (cmd.init_div) begin
			d_q   <= DIV_FIRST;
			dsq_q <= DSQ_FIRST;
		end else if (cmd.next_div) begin
			d_q   <= d_q + DIV_W'(2);
			dsq_q <= dsq_q + {{(DSQ_W-DIV_W-2){1'b0}}, d_q, 2'b00} + DSQ_W'(4);
		end
		if (cmd.load_out) begin
			prime_q <= cand_q;
		end
	end

	npf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_rem),
		.dividend (cand_q),
		.divisor  (d_q),
		.done     (rem_done),
		.zero     (rem_zero)
	);

	always_comb begin
		sts.cand_le3  = (cand_q <= CAND_THREE);
		sts.cand_even = !cand_q[0];
		sts.dsq_gt    = (dsq_q > {{(DSQ_W-CAND_W){1'b0}}, cand_q});
		sts.rem_done  = rem_done;
		sts.rem_zero  = rem_zero;
	end

	assign prime = prime_q;

endmodule
`default_nettype wire

FILE: rtl/core/npf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder controller
// Sequences candidate tests and trial divisions and owns the handshakes.
// ----------------------------------------------------------------------------
module npf_ctrl
	import npf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire npf_sts_t sts,
	output npf_cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_TEST  = 3'd1;
	localparam logic [2:0] ST_CHKD  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;
	localparam logic [2:0] ST_FOUND = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.cand_le3) begin
					state_d = ST_FOUND;
				end else if (sts.cand_even) begin
					state_d = ST_NEXT;
				end else begin
					cmd.init_div = 1'b1;
					state_d      = ST_CHKD;
				end
			end
			ST_CHKD: begin
				if (sts.dsq_gt) begin
					state_d = ST_FOUND;
				end else begin
					cmd.start_rem = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.rem_done) begin
					if (sts.rem_zero) begin
						state_d = ST_NEXT;
					end else begin
						cmd.next_div = 1'b1;
						state_d      = ST_CHKD;
					end
				end
			end
			ST_NEXT: begin
				cmd.next_cand = 1'b1;
				state_d       = ST_TEST;
			end
			ST_FOUND: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/npf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Next prime finder checker
// Port-level properties of the unit, bound to the top level.
// ----------------------------------------------------------------------------
module npf_checker
	import npf_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [IN_W-1:0]   start_value,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [CAND_W-1:0] prime
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(start_value))
		else $error("Input word changed while waiting.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prime))
		else $error("Output word changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken again while a word is in progress.");

	a_prime_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prime >= CAND_TWO)
		else $error("Result below two.");

	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prime[0] || prime == CAND_TWO)
		else $error("Even result other than two.");

endmodule

bind next_prime_finder_unit npf_checker u_npf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.start_value (start_value),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.prime       (prime)
);
`default_nettype wire

FILE: tb/sv/next_prime_finder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next prime finder unit testbench
// Sends signed start values through the valid/ready input channel and checks
// every output word against the smallest prime at or above the start value,
// computed here by trial division. Both channels idle at random, and the
// receiver holds off once for a long stretch so that the unit backs up.
// ----------------------------------------------------------------------------
module next_prime_finder_unit_tb;

	import npf_pkg::*;

	localparam int RANDOM_WORDS = 100;
	localparam int CALM_TAIL    = 20;
	localparam int HOLD_CYCLES  = 40000;
	localparam int HOLD_AFTER   = 30;
	localparam int STALL_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [IN_W-1:0]   start_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CAND_W-1:0] prime;

	logic [IN_W-1:0]   start_values[$];
	logic [CAND_W-1:0] expected_primes[$];
	logic              in_taken = 1'b0;
	int                words_in = 0;
	int                words_out = 0;
	int                total_words = 0;
	int                errors = 0;
	int                in_gap = 0;
	int                out_gap = 0;
	int                hold_left = 0;
	bit                hold_done = 0;
	int                quiet_cycles = 0;

	next_prime_finder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.start_value (start_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.prime       (prime)
	);

	always #1 clk = ~clk;

	function automatic bit is_prime(logic [31:0] n);
		logic [63:0] d;
		if (n < 2)
			return 0;
		if (n < 4)
			return 1;
		if (n[0] == 1'b0 || n % 3 == 0)
			return 0;
		for (d = 5; d * d <= n; d += 2) begin
			if (n % d == 0)
				return 0;
		end
		return 1;
	endfunction

	function automatic logic [CAND_W-1:0] next_prime_at(logic [IN_W-1:0] v);
		logic [31:0] n;
		if (v[IN_W-1] || v < 2)
			return CAND_TWO;
		n = v;
		while (n < 32'h7FFF_FFFF && !is_prime(n))
			n++;
		return n[CAND_W-1:0];
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (start_values.size() > 0) begin
				in_valid <= 1'b1;
				start_value <= start_values.pop_front();
				if (start_values.size() > CALM_TAIL && $urandom_range(0, 3) == 0)
					in_gap = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!hold_done && words_in >= HOLD_AFTER) begin
			hold_done = 1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (words_out < total_words - CALM_TAIL && $urandom_range(0, 3) == 0)
				out_gap = $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin : word_monitor
		logic [CAND_W-1:0] want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				words_out <= words_out + 1;
				if (expected_primes.size() == 0) begin
					$error("prime: expected none, actual %0d", prime);
					errors++;
				end else begin
					want = expected_primes.pop_front();
					if (prime !== want) begin
						$error("prime: expected %0d, actual %0d", want, prime);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_primes.push_back(next_prime_at(start_value));
				words_in <= words_in + 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [IN_W-1:0] v;
		int sel;
		start_values.push_back(32'h8000_0000);
		start_values.push_back(32'hFFFF_FFFF);
		for (int k = 0; k <= 9; k++)
			start_values.push_back(k);
		start_values.push_back(24);
		start_values.push_back(25);
		start_values.push_back(49);
		start_values.push_back(90);
		start_values.push_back(121);
		start_values.push_back(65521);
		start_values.push_back(65522);
		start_values.push_back(1000000);
		start_values.push_back(32'h7FFF_FFFF);
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			sel = $urandom_range(0, 19);
			if (sel < 3)
				v = $urandom | 32'h8000_0000;
			else if (sel < 4)
				v = $urandom_range(0, 1);
			else if (sel < 16)
				v = $urandom_range(2, 4000);
			else if (sel < 19)
				v = $urandom_range(4001, 40000);
			else
				v = $urandom_range(40001, 1 << 20);
			start_values.push_back(v);
		end
		total_words = start_values.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_in < total_words)
			@(posedge clk);
		while (expected_primes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
